// ===== sv/lpf_pkg.sv =====
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared constants and types of the length-prefixed packet ring FIFO.
// ----------------------------------------------------------------------------
package lpf_pkg;

   localparam int RING_BYTES = 4096;
   localparam int HDR_BYTES  = 2;
   localparam int PTR_W      = $clog2(RING_BYTES);
   localparam int STORED_W   = $clog2(RING_BYTES + 1);
   localparam int LEN_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int REQ_W      = 2;
   localparam int STATUS_W   = 3;
   localparam int FREE_W     = 13;
   localparam int ROOM_W     = LEN_W + 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_START = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_ROOM    = 3'd1,
      ST_ZERO_LEN   = 3'd2,
      ST_EMPTY      = 3'd3,
      ST_OUT_OF_SEQ = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_LEN_LOW  = 2'd0,
      PH_LEN_HIGH = 2'd1,
      PH_PAYLOAD  = 2'd2
   } read_phase_type;

   typedef enum logic [1:0] {
      S_IDLE      = 2'd0,
      S_HDR_HIGH  = 2'd1,
      S_READ_DATA = 2'd2
   } fsm_state_type;

endpackage

// ===== sv/lpf_ram.sv =====
// ----------------------------------------------------------------------------
// lpf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/length_prefixed_packet_ring_fifo_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_fifo_core
// Byte ring holding packets as a two-byte little-endian length and payload.
//
//   channel   ports                                      handshake
//   request   req_type, req_pkt_len, req_data_byte       start high, busy low
//   response  rsp_status, rsp_data_out, rsp_last,        rsp_valid, one cycle
//             rsp_free_bytes
//
// A write-byte item and any refused item answer in the cycle after acceptance.
// An accepted start passes through S_HDR_HIGH, since both header bytes go
// through the single write port of the ring memory; a read passes through
// S_READ_DATA for the registered read of that memory. Busy is high meanwhile.
// Reset clears the pointers and counters; the ring memory needs no clearing.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring_fifo_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lpf_pkg::REQ_W-1:0]     req_type,
   input  logic [lpf_pkg::LEN_W-1:0]     req_pkt_len,
   input  logic [lpf_pkg::BYTE_W-1:0]    req_data_byte,
   output logic                          rsp_valid,
   output logic [lpf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [lpf_pkg::BYTE_W-1:0]    rsp_data_out,
   output logic                          rsp_last,
   output logic [lpf_pkg::FREE_W-1:0]    rsp_free_bytes
);

   import lpf_pkg::*;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [STORED_W-1:0] span(input logic [PTR_W-1:0] from,
                                                input logic [PTR_W-1:0] to);
      logic [STORED_W-1:0] diff;
      diff = STORED_W'(to) - STORED_W'(from);
      if (to < from) begin
         diff = diff + STORED_W'(RING_BYTES);
      end
      return diff;
   endfunction

   fsm_state_type        state_ff, state_in;
   logic [PTR_W-1:0]     read_pos_ff, read_pos_in;
   logic [PTR_W-1:0]     write_pos_ff, write_pos_in;
   logic [PTR_W-1:0]     commit_pos_ff, commit_pos_in;
   logic [LEN_W-1:0]     write_left_ff, write_left_in;
   read_phase_type       read_phase_ff, read_phase_in;
   logic [LEN_W-1:0]     read_left_ff, read_left_in;
   logic [BYTE_W-1:0]    len_low_ff, len_low_in;
   logic [BYTE_W-1:0]    len_high_ff, len_high_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [FREE_W-1:0]    rsp_free_ff, rsp_free_in;

   logic                 ram_we;
   logic [PTR_W-1:0]     ram_wa;
   logic [BYTE_W-1:0]    ram_wd;
   logic                 ram_re;
   logic [BYTE_W-1:0]    ram_rd;

   lpf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (read_pos_ff),
      .rd_data (ram_rd)
   );

   always_comb begin
      logic [STORED_W-1:0] stored_now;
      logic [LEN_W-1:0]    left_dec;
      logic                respond;
      status_type          status;
      logic [BYTE_W-1:0]   dout;
      logic                last;

      state_in      = state_ff;
      read_pos_in   = read_pos_ff;
      write_pos_in  = write_pos_ff;
      commit_pos_in = commit_pos_ff;
      write_left_in = write_left_ff;
      read_phase_in = read_phase_ff;
      read_left_in  = read_left_ff;
      len_low_in    = len_low_ff;
      len_high_in   = len_high_ff;
      ram_we        = 1'b0;
      ram_wa        = write_pos_ff;
      ram_wd        = req_data_byte;
      ram_re        = 1'b0;
      respond       = 1'b0;
      status        = ST_OK;
      dout          = '0;
      last          = 1'b0;
      left_dec      = read_left_ff;
      stored_now    = span(read_pos_ff, write_pos_ff);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               respond = 1'b1;
               case (req_code_type'(req_type))
                  REQ_START: begin
                     if (write_left_ff != '0) begin
                        status = ST_OUT_OF_SEQ;
                     end else if (ROOM_W'(stored_now) + ROOM_W'(req_pkt_len)
                                  + ROOM_W'(HDR_BYTES) > ROOM_W'(RING_BYTES - 1)) begin
                        status = ST_NO_ROOM;
                     end else if (req_pkt_len == '0) begin
                        status = ST_ZERO_LEN;
                     end else begin
                        respond       = 1'b0;
                        ram_we        = 1'b1;
                        ram_wd        = req_pkt_len[BYTE_W-1:0];
                        write_pos_in  = advance(write_pos_ff);
                        write_left_in = req_pkt_len;
                        len_high_in   = req_pkt_len[LEN_W-1:BYTE_W];
                        state_in      = S_HDR_HIGH;
                     end
                  end
                  REQ_WRITE: begin
                     if (write_left_ff == '0) begin
                        status = ST_OUT_OF_SEQ;
                     end else begin
                        ram_we        = 1'b1;
                        write_pos_in  = advance(write_pos_ff);
                        write_left_in = write_left_ff - 1'b1;
                        if (write_left_ff == LEN_W'(1)) begin
                           commit_pos_in = advance(write_pos_ff);
                           last          = 1'b1;
                        end
                     end
                  end
                  REQ_READ: begin
                     if (read_pos_ff == commit_pos_ff) begin
                        status = ST_EMPTY;
                     end else begin
                        respond     = 1'b0;
                        ram_re      = 1'b1;
                        read_pos_in = advance(read_pos_ff);
                        state_in    = S_READ_DATA;
                     end
                  end
                  default: begin
                     status = ST_OUT_OF_SEQ;
                  end
               endcase
            end
         end
         S_HDR_HIGH: begin
            ram_we       = 1'b1;
            ram_wd       = len_high_ff;
            write_pos_in = advance(write_pos_ff);
            respond      = 1'b1;
            state_in     = S_IDLE;
         end
         S_READ_DATA: begin
            dout     = ram_rd;
            respond  = 1'b1;
            state_in = S_IDLE;
            case (read_phase_ff)
               PH_LEN_HIGH: begin
                  read_left_in  = {ram_rd, len_low_ff};
                  read_phase_in = PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  if (read_left_ff != '0) begin
                     left_dec = read_left_ff - 1'b1;
                  end
                  read_left_in = left_dec;
                  if (left_dec == '0) begin
                     last          = 1'b1;
                     read_phase_in = PH_LEN_LOW;
                  end
               end
               default: begin
                  len_low_in    = ram_rd;
                  read_phase_in = PH_LEN_HIGH;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = respond;
      rsp_status_in = respond ? status : rsp_status_ff;
      rsp_data_in   = respond ? dout : rsp_data_ff;
      rsp_last_in   = respond ? last : rsp_last_ff;
      rsp_free_in   = respond ?
                      FREE_W'(STORED_W'(RING_BYTES) - span(read_pos_in, write_pos_in)) :
                      rsp_free_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         read_pos_ff   <= '0;
         write_pos_ff  <= '0;
         commit_pos_ff <= '0;
         write_left_ff <= '0;
         read_phase_ff <= PH_LEN_LOW;
         read_left_ff  <= '0;
         len_low_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         read_pos_ff   <= read_pos_in;
         write_pos_ff  <= write_pos_in;
         commit_pos_ff <= commit_pos_in;
         write_left_ff <= write_left_in;
         read_phase_ff <= read_phase_in;
         read_left_ff  <= read_left_in;
         len_low_ff    <= len_low_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_high_ff   <= len_high_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_free_bytes = rsp_free_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("A result was shown while an item is still in progress.");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("An accepted item neither answered nor kept the block busy.");

   a_header_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HDR_HIGH) |=> (rsp_valid && rsp_status == ST_OK))
      else $error("A started packet did not answer after its second header byte.");

   a_refusal_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_data_out == '0 && !rsp_last))
      else $error("A refused item carried data or a last mark.");

endmodule

// ===== dv/length_prefixed_packet_ring_fifo_core_tb.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_packet_ring_fifo_core_tb
// Self-checking bench for the packet ring FIFO. A scoreboard keeps its own
// copy of the ring, its pointers and the read-out phase, and predicts the
// response to each item the block accepts. Directed items come first, then
// random packet traffic under three sender idling patterns.
// ----------------------------------------------------------------------------
module length_prefixed_packet_ring_fifo_core_tb;

   import lpf_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   data;
      logic                last;
      logic [FREE_W-1:0]   free;
   } ring_response_type;

   class packet_ring_scoreboard;
      logic [BYTE_W-1:0] ring [RING_BYTES];
      logic [PTR_W-1:0]  rd_ptr;
      logic [PTR_W-1:0]  wr_ptr;
      logic [PTR_W-1:0]  commit_ptr;
      logic [LEN_W-1:0]  bytes_to_write;
      logic [LEN_W-1:0]  bytes_to_read;
      logic [BYTE_W-1:0] len_low;
      read_phase_type    phase;
      ring_response_type expected_responses[$];
      int                failures;

      function new();
         rd_ptr = '0;
         wr_ptr = '0;
         commit_ptr = '0;
         bytes_to_write = '0;
         bytes_to_read = '0;
         len_low = '0;
         phase = PH_LEN_LOW;
         failures = 0;
      endfunction

      function int fill_level();
         return (int'(wr_ptr) + RING_BYTES - int'(rd_ptr)) % RING_BYTES;
      endfunction

      function logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
         return (int'(p) == RING_BYTES - 1) ? '0 : p + 1'b1;
      endfunction

      function void push_byte(logic [BYTE_W-1:0] b);
         ring[wr_ptr] = b;
         wr_ptr = next_ptr(wr_ptr);
      endfunction

      function logic [BYTE_W-1:0] pop_byte();
         logic [BYTE_W-1:0] b;
         b = ring[rd_ptr];
         rd_ptr = next_ptr(rd_ptr);
         return b;
      endfunction

      function void note_request(logic [REQ_W-1:0] kind, logic [LEN_W-1:0] len,
                                 logic [BYTE_W-1:0] b);
         ring_response_type exp;
         exp.status = ST_OK;
         exp.data = '0;
         exp.last = 1'b0;
         if (kind == REQ_START) begin
            if (bytes_to_write != 0)
               exp.status = ST_OUT_OF_SEQ;
            else if (fill_level() + int'(len) + HDR_BYTES > RING_BYTES - 1)
               exp.status = ST_NO_ROOM;
            else if (len == 0)
               exp.status = ST_ZERO_LEN;
            else begin
               push_byte(len[7:0]);
               push_byte(len[15:8]);
               bytes_to_write = len;
            end
         end else if (kind == REQ_WRITE) begin
            if (bytes_to_write == 0)
               exp.status = ST_OUT_OF_SEQ;
            else begin
               push_byte(b);
               bytes_to_write = bytes_to_write - 1'b1;
               if (bytes_to_write == 0) begin
                  commit_ptr = wr_ptr;
                  exp.last = 1'b1;
               end
            end
         end else if (kind == REQ_READ) begin
            if (rd_ptr == commit_ptr)
               exp.status = ST_EMPTY;
            else begin
               exp.data = pop_byte();
               case (phase)
                  PH_LEN_HIGH: begin
                     bytes_to_read = {exp.data, len_low};
                     phase = PH_PAYLOAD;
                  end
                  PH_PAYLOAD: begin
                     if (bytes_to_read != 0)
                        bytes_to_read = bytes_to_read - 1'b1;
                     if (bytes_to_read == 0) begin
                        exp.last = 1'b1;
                        phase = PH_LEN_LOW;
                     end
                  end
                  default: begin
                     len_low = exp.data;
                     phase = PH_LEN_HIGH;
                  end
               endcase
            end
         end else
            exp.status = ST_OUT_OF_SEQ;
         exp.free = FREE_W'(RING_BYTES - fill_level());
         expected_responses.push_back(exp);
      endfunction

      function void check_response(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] d,
                                   logic l, logic [FREE_W-1:0] f);
         ring_response_type got;
         ring_response_type exp;
         got.status = st;
         got.data = d;
         got.last = l;
         got.free = f;
         if (expected_responses.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("Unexpected response: status %0d data %02h last %0b free %0d",
                        st, d, l, f);
            return;
         end
         exp = expected_responses.pop_front();
         if (got !== exp) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("Mismatch: expected status %0d data %02h last %0b free %0d, %s",
                        exp.status, exp.data, exp.last, exp.free,
                        $sformatf("got status %0d data %02h last %0b free %0d",
                                  st, d, l, f));
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [REQ_W-1:0]    req_type = '0;
   logic [LEN_W-1:0]    req_pkt_len = '0;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_data_out;
   logic                rsp_last;
   logic [FREE_W-1:0]   rsp_free_bytes;

   packet_ring_scoreboard sb = new();
   int idle_pct = 0;
   int cycle_count = 0;

   length_prefixed_packet_ring_fifo_core DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_pkt_len    (req_pkt_len),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_last       (rsp_last),
      .rsp_free_bytes (rsp_free_bytes)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_status, rsp_data_out, rsp_last, rsp_free_bytes);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_item(input logic [REQ_W-1:0] kind, input logic [LEN_W-1:0] len,
                            input logic [BYTE_W-1:0] b);
      start <= 1'b1;
      req_type <= kind;
      req_pkt_len <= len;
      req_data_byte <= b;
      do @(posedge clock); while (busy);
      sb.note_request(kind, len, b);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
   endtask

   task automatic drain_responses();
      if (start)
         start <= 1'b0;
      while (sb.expected_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic directed_items();
      send_item(REQ_READ, '0, '0);
      send_item(REQ_WRITE, '0, 8'hA5);
      send_item(REQ_UNKNOWN, 16'hFFFF, 8'hFF);
      send_item(REQ_START, 16'd0, '0);
      send_item(REQ_START, 16'hFFFF, '0);
      send_item(REQ_START, LEN_W'(RING_BYTES - HDR_BYTES), '0);
      send_item(REQ_START, 16'd2, '0);
      send_item(REQ_START, 16'd1, '0);
      send_item(REQ_READ, '0, '0);
      send_item(REQ_WRITE, '0, 8'h00);
      send_item(REQ_WRITE, '0, 8'hFF);
      send_item(REQ_START, 16'd1, '0);
      send_item(REQ_WRITE, '0, 8'h5A);
      repeat (8) send_item(REQ_READ, '0, '0);
      send_item(REQ_READ, '0, '0);
   endtask

   task automatic random_items(input int count);
      int n;
      int r;
      int pick;
      logic [REQ_W-1:0] kind;
      logic [LEN_W-1:0] len;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (sb.bytes_to_write != 0) begin
            if (r < 70) kind = REQ_WRITE;
            else if (r < 90) kind = REQ_READ;
            else if (r < 95) kind = REQ_START;
            else kind = REQ_UNKNOWN;
         end else begin
            if (r < 35) kind = REQ_START;
            else if (r < 85) kind = REQ_READ;
            else if (r < 95) kind = REQ_WRITE;
            else kind = REQ_UNKNOWN;
         end
         pick = $urandom_range(0, 99);
         if (pick < 80) len = LEN_W'($urandom_range(1, 12));
         else if (pick < 88) len = LEN_W'($urandom_range(13, 400));
         else if (pick < 94) len = '0;
         else len = LEN_W'($urandom_range(0, 65535));
         send_item(kind, len, BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_pct = 10;
      directed_items();
      random_items(300);
      drain_responses();
      idle_pct = 67;
      random_items(300);
      drain_responses();
      idle_pct = 0;
      random_items(300);
      drain_responses();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.expected_responses.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
